FILE: design/counter_based_random_draw_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the counter-based random draw
// Shared property templates for the port checker.
// ---------------------------------------------------------------------------
`ifndef COUNTER_BASED_RANDOM_DRAW_ASSERT_SVH
`define COUNTER_BASED_RANDOM_DRAW_ASSERT_SVH

// Same-cycle implication, held off while reset is high.
`define CBRD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off while reset is high.
`define CBRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/cbrd_pkg.sv
// ---------------------------------------------------------------------------
// cbrd_pkg
// Constants, codes and shared types of the counter-based random draw.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbrd_pkg;

   localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_M1 = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_M2 = 64'h94D0_49BB_1331_11EB;

   localparam logic [5:0] PRE_SHIFT = 6'd30;
   localparam logic [4:0] M1_SHIFT  = 5'd27;
   localparam logic [4:0] M2_SHIFT  = 5'd31;

   // Register stages from input to result register.
   localparam int unsigned PIPE_DEPTH = 13;

   typedef enum logic [1:0] {
      FUNC_RAW = 2'd0,
      FUNC_INT = 2'd1,
      FUNC_FIX = 2'd2
   } func_type;

   typedef enum logic {
      ROUND_M1,
      ROUND_M2
   } round_type;

   // Sideband that travels alongside the hash word.
   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic [32:0]        span;
      logic [31:0]        raw;
   } side_type;

endpackage

FILE: design/counter_based_random_draw.sv
// ---------------------------------------------------------------------------
// counter_based_random_draw
// Stateless pseudo-random draw keyed by (seed, salt) through a pipelined
// splitmix64 hash, with raw, integer-uniform and Q16.16-uniform outputs.
// ---------------------------------------------------------------------------
//
//   channel | direction | tdata (low bit up)                      | tuser
//   --------+-----------+-----------------------------------------+-------------
//   req_    | in        | seed, salt, range_start, range_end      | func [1:0]
//   rsp_    | out       | value                                   | -
//
// rsp_tvalid rises once an accepted request has passed all 13 register stages,
// the first loaded on the accepting edge; a new request is taken every cycle,
// set by the one-item-per-stage pipeline, unless a stall fills it to the input.
// Each of the four finaliser rounds spends one stage on 32x32 partial
// products and one on recombination and xorshift.
// A stalled response freezes only the stages behind it that are full;
// empty stages keep filling, so bubbles are squeezed out.
// Synchronous active-high reset clears the valid bits only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module counter_based_random_draw (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // seed, salt, range_start, range_end
   input  logic [1:0]   req_tuser,  // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata   // value
);

   // Request fields
   logic [31:0]        seed;
   logic [31:0]        salt;
   logic signed [31:0] range_start;
   logic signed [31:0] range_end;
   logic [63:0]        key_x;

   // Input stage: key whitening and bound ordering
   logic               i_ready;
   logic               i_valid_ff, i_valid_in;
   logic [63:0]        i_x_ff, i_x_in;
   cbrd_pkg::side_type i_side_ff, i_side_in;

   // First finaliser
   logic               r1_ready, r1_valid, r2_ready, r2_valid;
   logic [63:0]        r1_x, r2_x;
   cbrd_pkg::side_type r1_side, r2_side;

   // Glue stage: capture the raw draw, re-key, work out the span
   logic               g_ready;
   logic               g_valid_ff, g_valid_in;
   logic [63:0]        g_t;
   logic [63:0]        g_x_ff, g_x_in;
   logic [32:0]        g_diff;
   cbrd_pkg::side_type g_side_ff, g_side_in;

   // Second finaliser
   logic               r3_ready, r3_valid, r4_ready, r4_valid;
   logic [63:0]        r3_x, r4_x;
   cbrd_pkg::side_type r3_side, r4_side;

   logic               sc_ready;

   assign seed        = req_tdata[31:0];
   assign salt        = req_tdata[63:32];
   assign range_start = req_tdata[95:64];
   assign range_end   = req_tdata[127:96];

   // Whiten the key and apply the first pre-shift of the finaliser.
   assign key_x  = {seed, salt} ^ cbrd_pkg::GOLDEN;
   assign i_x_in = key_x ^ (key_x >> cbrd_pkg::PRE_SHIFT);

   always_comb begin
      i_side_in      = '0;
      i_side_in.func = req_tuser;
      // Swap reversed bounds.
      if (range_end < range_start) begin
         i_side_in.lo = range_end;
         i_side_in.hi = range_start;
      end else begin
         i_side_in.lo = range_start;
         i_side_in.hi = range_end;
      end
   end

   assign i_ready    = !i_valid_ff || r1_ready;
   assign i_valid_in = i_ready ? req_tvalid : i_valid_ff;

   cbrd_mix_round u_round1 (
      .clock     (clock),
      .reset     (reset),
      .round_sel (cbrd_pkg::ROUND_M1),
      .in_valid  (i_valid_ff),
      .in_ready  (r1_ready),
      .in_x      (i_x_ff),
      .in_side   (i_side_ff),
      .out_valid (r1_valid),
      .out_ready (r2_ready),
      .out_x     (r1_x),
      .out_side  (r1_side)
   );

   cbrd_mix_round u_round2 (
      .clock     (clock),
      .reset     (reset),
      .round_sel (cbrd_pkg::ROUND_M2),
      .in_valid  (r1_valid),
      .in_ready  (r2_ready),
      .in_x      (r1_x),
      .in_side   (r1_side),
      .out_valid (r2_valid),
      .out_ready (g_ready),
      .out_x     (r2_x),
      .out_side  (r2_side)
   );

   // r2_x is the first hash s; advance it by the golden step and pre-shift.
   assign g_t    = r2_x + cbrd_pkg::GOLDEN;
   assign g_x_in = g_t ^ (g_t >> cbrd_pkg::PRE_SHIFT);

   // Bound difference, plus one for the inclusive integer range.
   assign g_diff = {r2_side.hi[31], r2_side.hi} - {r2_side.lo[31], r2_side.lo};

   always_comb begin
      g_side_in     = r2_side;
      g_side_in.raw = r2_x[52:21];
      if (r2_side.func == cbrd_pkg::FUNC_INT) begin
         g_side_in.span = g_diff + 33'd1;
      end else begin
         g_side_in.span = g_diff;
      end
   end

   assign g_ready    = !g_valid_ff || r3_ready;
   assign g_valid_in = g_ready ? r2_valid : g_valid_ff;

   cbrd_mix_round u_round3 (
      .clock     (clock),
      .reset     (reset),
      .round_sel (cbrd_pkg::ROUND_M1),
      .in_valid  (g_valid_ff),
      .in_ready  (r3_ready),
      .in_x      (g_x_ff),
      .in_side   (g_side_ff),
      .out_valid (r3_valid),
      .out_ready (r4_ready),
      .out_x     (r3_x),
      .out_side  (r3_side)
   );

   cbrd_mix_round u_round4 (
      .clock     (clock),
      .reset     (reset),
      .round_sel (cbrd_pkg::ROUND_M2),
      .in_valid  (r3_valid),
      .in_ready  (r4_ready),
      .in_x      (r3_x),
      .in_side   (r3_side),
      .out_valid (r4_valid),
      .out_ready (sc_ready),
      .out_x     (r4_x),
      .out_side  (r4_side)
   );

   // Top 53 bits of the second hash form the fraction.
   cbrd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r4_valid),
      .in_ready  (sc_ready),
      .in_m      (r4_x[63:11]),
      .in_side   (r4_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_tdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else begin
         i_valid_ff <= i_valid_in;
         g_valid_ff <= g_valid_in;
      end
   end

   // Payload registers load whenever their stage may advance.
   always_ff @(posedge clock) begin
      if (i_ready) begin
         i_x_ff    <= i_x_in;
         i_side_ff <= i_side_in;
      end
      if (g_ready) begin
         g_x_ff    <= g_x_in;
         g_side_ff <= g_side_in;
      end
   end

   assign req_tready = i_ready;

endmodule

FILE: design/cbrd_mix_round.sv
// ---------------------------------------------------------------------------
// cbrd_mix_round
// One multiply-xorshift round of the finaliser over two register stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbrd_mix_round (
   input  logic                clock,
   input  logic                reset,
   input  cbrd_pkg::round_type round_sel,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [63:0]         in_x,
   input  cbrd_pkg::side_type  in_side,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [63:0]         out_x,
   output cbrd_pkg::side_type  out_side
);

   logic [63:0]        mult;
   logic [4:0]         shift;

   logic               p_ready;
   logic               p_valid_ff, p_valid_in;
   logic [63:0]        p_ll_ff, p_ll_in;
   logic [31:0]        p_hl_ff, p_hl_in;
   logic [31:0]        p_lh_ff, p_lh_in;
   cbrd_pkg::side_type p_side_ff;

   logic               s_ready;
   logic               s_valid_ff, s_valid_in;
   logic [63:0]        sum;
   logic [63:0]        s_x_ff, s_x_in;
   cbrd_pkg::side_type s_side_ff;

   always_comb begin
      case (round_sel)
         cbrd_pkg::ROUND_M2: begin
            mult  = cbrd_pkg::MIX_M2;
            shift = cbrd_pkg::M2_SHIFT;
         end
         default: begin
            mult  = cbrd_pkg::MIX_M1;
            shift = cbrd_pkg::M1_SHIFT;
         end
      endcase
   end

   // Partial products; the upper cross terms only matter modulo 2^32.
   assign p_ll_in = in_x[31:0] * mult[31:0];
   assign p_hl_in = in_x[63:32] * mult[31:0];
   assign p_lh_in = in_x[31:0] * mult[63:32];

   // Recombine and fold the high bits back down.
   assign sum    = p_ll_ff + {p_hl_ff + p_lh_ff, 32'd0};
   assign s_x_in = sum ^ (sum >> shift);

   assign s_ready    = !s_valid_ff || out_ready;
   assign p_ready    = !p_valid_ff || s_ready;
   assign p_valid_in = p_ready ? in_valid : p_valid_ff;
   assign s_valid_in = s_ready ? p_valid_ff : s_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready) begin
         p_ll_ff   <= p_ll_in;
         p_hl_ff   <= p_hl_in;
         p_lh_ff   <= p_lh_in;
         p_side_ff <= in_side;
      end
      if (s_ready) begin
         s_x_ff    <= s_x_in;
         s_side_ff <= p_side_ff;
      end
   end

   assign in_ready  = p_ready;
   assign out_valid = s_valid_ff;
   assign out_x     = s_x_ff;
   assign out_side  = s_side_ff;

endmodule

FILE: design/cbrd_scale.sv
// ---------------------------------------------------------------------------
// cbrd_scale
// Scale a 53-bit fraction onto the span, offset, clamp and select the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbrd_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [52:0]        in_m,
   input  cbrd_pkg::side_type in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [31:0]        out_value
);

   // Stage 1: partial products of fraction and span
   logic               a_ready;
   logic               a_valid_ff, a_valid_in;
   logic [53:0]        a_ph_ff, a_ph_in;
   logic [64:0]        a_pl_ff, a_pl_in;
   cbrd_pkg::side_type a_side_ff;

   // Stage 2: floor of the product
   logic               b_ready;
   logic               b_valid_ff, b_valid_in;
   logic [53:0]        b_sum;
   logic [32:0]        b_q_ff, b_q_in;
   cbrd_pkg::side_type b_side_ff;

   // Stage 3: offset, clamp and select
   logic               c_ready;
   logic               c_valid_ff, c_valid_in;
   logic signed [33:0] c_lo_wide;
   logic signed [33:0] c_hi_wide;
   logic signed [33:0] c_r_wide;
   logic [31:0]        c_value_ff, c_value_in;

   assign a_ph_in = in_m[52:32] * in_side.span;
   assign a_pl_in = in_m[31:0] * in_side.span;

   assign b_sum  = a_ph_ff + {21'd0, a_pl_ff[64:32]};
   assign b_q_in = b_sum[53:21];

   assign c_lo_wide = {{2{b_side_ff.lo[31]}}, b_side_ff.lo};
   assign c_hi_wide = {{2{b_side_ff.hi[31]}}, b_side_ff.hi};
   assign c_r_wide  = c_lo_wide + $signed({1'b0, b_q_ff});

   always_comb begin
      case (b_side_ff.func)
         cbrd_pkg::FUNC_RAW: c_value_in = b_side_ff.raw;
         cbrd_pkg::FUNC_INT: begin
            // Clamp to the upper bound.
            if (c_r_wide > c_hi_wide) begin
               c_value_in = b_side_ff.hi;
            end else begin
               c_value_in = c_r_wide[31:0];
            end
         end
         cbrd_pkg::FUNC_FIX: c_value_in = c_r_wide[31:0];
         default:            c_value_in = 32'd0;
      endcase
   end

   assign c_ready    = !c_valid_ff || out_ready;
   assign b_ready    = !b_valid_ff || c_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_ph_ff   <= a_ph_in;
         a_pl_ff   <= a_pl_in;
         a_side_ff <= in_side;
      end
      if (b_ready) begin
         b_q_ff    <= b_q_in;
         b_side_ff <= a_side_ff;
      end
      if (c_ready) begin
         c_value_ff <= c_value_in;
      end
   end

   assign in_ready  = a_ready;
   assign out_valid = c_valid_ff;
   assign out_value = c_value_ff;

endmodule

FILE: design/cbrd_port_checker.sv
// ---------------------------------------------------------------------------
// cbrd_port_checker
// Port-level checks of the random draw, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "counter_based_random_draw_assert.svh"

module cbrd_port_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata   // value
);

   localparam int unsigned CNT_W = $clog2(cbrd_pkg::PIPE_DEPTH + 1);

   logic             req_fire;
   logic             rsp_fire;
   logic [CNT_W-1:0] pending_ff, pending_in;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Track transactions taken in but not yet delivered.
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + CNT_W'(1);
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `CBRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response dropped or changed while stalled")
   `CBRD_ASSERT_IMPLY(a_no_orphan, clock, reset, rsp_tvalid, pending_ff != '0, "response without a pending request")
   `CBRD_ASSERT_IMPLY(a_depth, clock, reset, 1'b1, pending_ff <= CNT_W'(cbrd_pkg::PIPE_DEPTH), "more transactions in flight than pipeline stages")
   `CBRD_ASSERT_IMPLY(a_ready_free, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "request back-pressured without a stalled response")

endmodule

bind counter_based_random_draw cbrd_port_checker u_port_checker (.*);
